[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for clocked implication checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ssaa_pkg.sv]
// ----------------------------------------------------------------------------
// ssaa_pkg
// Types and constants shared by the supersampled shape pixel shader.
// ----------------------------------------------------------------------------
package ssaa_pkg;

    localparam int SPA_DEF   = 4;
    localparam int COLOR_ONE = 4095;
    localparam int PIX_W     = 12;
    localparam int COLOR_W   = 12;
    localparam int COUNT_W   = 5;
    localparam int COUNT_MAX = 31;
    localparam int COORD_W   = 22;
    localparam int TERM_W    = 20;
    localparam int EDGE_W    = COORD_W + 1;
    localparam int PROD1_W   = TERM_W + PIX_W + 1;
    localparam int BASE_W    = PROD1_W + 2;
    localparam int FULL_W    = BASE_W + 8;
    localparam int OBJ_W     = FULL_W - 12;
    localparam int DIF_W     = OBJ_W + 1;
    localparam int SQ_W      = 64;
    localparam int BLEND_W   = 2 * COLOR_W + 1;
    localparam int BGW_W     = 2 * COLOR_W;
    localparam int NUM_W     = 32;
    localparam int QUO_W     = COLOR_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;

    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_KIND    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_ROW_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_ROW_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_A       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_B       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_C       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED        = 3'd7;

    localparam logic [1:0] KIND_CIRCLE = 2'd0;
    localparam logic [1:0] KIND_RECT   = 2'd1;
    localparam logic [1:0] KIND_TRI    = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_x;
        logic [PIX_W-1:0]   pixel_y;
        logic [COLOR_W-1:0] bg_red;
        logic [COLOR_W-1:0] bg_green;
        logic [COLOR_W-1:0] bg_blue;
    } pix_item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] out_red;
        logic [COLOR_W-1:0] out_green;
        logic [COLOR_W-1:0] out_blue;
        logic [COUNT_W-1:0] covered_samples;
    } res_item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } color_t;

    typedef struct packed {
        logic [1:0]  shape_kind;
        logic [59:0] inverse_row_x;
        logic [59:0] inverse_row_y;
        logic [43:0] point_a;
        logic [43:0] point_b;
        logic [43:0] point_c;
        logic [47:0] fill_color_alpha;
    } cfg_t;

endpackage

[sv/ssaa_cfg.sv]
// ----------------------------------------------------------------------------
// ssaa_cfg
// Configuration register file written through the index/data port.
// ----------------------------------------------------------------------------
module ssaa_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ssaa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ssaa_pkg::CFG_DATA_W-1:0]     cfg_data,
    output ssaa_pkg::cfg_t                      cfg
);
    import ssaa_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SHAPE_KIND: cfg_next.shape_kind       = cfg_data[1:0];
                CFG_INV_ROW_X:  cfg_next.inverse_row_x    = cfg_data[59:0];
                CFG_INV_ROW_Y:  cfg_next.inverse_row_y    = cfg_data[59:0];
                CFG_POINT_A:    cfg_next.point_a          = cfg_data[43:0];
                CFG_POINT_B:    cfg_next.point_b          = cfg_data[43:0];
                CFG_POINT_C:    cfg_next.point_c          = cfg_data[43:0];
                CFG_FILL_COLOR: cfg_next.fill_color_alpha = cfg_data[47:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

endmodule

[sv/ssaa_map.sv]
// ----------------------------------------------------------------------------
// ssaa_map
// Three-stage mapping of every subpixel sample into object space.
// ----------------------------------------------------------------------------
module ssaa_map #(
    parameter int SAMPLES_PER_AXIS = ssaa_pkg::SPA_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  ssaa_pkg::cfg_t                  cfg,
    input  logic                            in_valid,
    input  ssaa_pkg::pix_item_t             in_item,
    output logic                            out_valid,
    output ssaa_pkg::color_t                out_bg,
    output logic signed [ssaa_pkg::OBJ_W-1:0] ox [SAMPLES_PER_AXIS*SAMPLES_PER_AXIS],
    output logic signed [ssaa_pkg::OBJ_W-1:0] oy [SAMPLES_PER_AXIS*SAMPLES_PER_AXIS]
);
    import ssaa_pkg::*;

    localparam int LANES = SAMPLES_PER_AXIS * SAMPLES_PER_AXIS;

    logic signed [TERM_W-1:0]  xcx, xcy, xt, ycx, ycy, yt;
    logic signed [PROD1_W-1:0] prod_next [4];
    logic signed [PROD1_W-1:0] prod_reg  [4];
    logic signed [BASE_W-1:0]  basex_next, basey_next, basex_reg, basey_reg;
    logic signed [OBJ_W-1:0]   ox_next [LANES];
    logic signed [OBJ_W-1:0]   oy_next [LANES];
    logic signed [OBJ_W-1:0]   ox_reg  [LANES];
    logic signed [OBJ_W-1:0]   oy_reg  [LANES];
    color_t                    bg1_reg, bg2_reg, bg3_reg;
    logic                      v1_reg, v2_reg, v3_reg;

    assign xcx = $signed(cfg.inverse_row_x[19:0]);
    assign xcy = $signed(cfg.inverse_row_x[39:20]);
    assign xt  = $signed(cfg.inverse_row_x[59:40]);
    assign ycx = $signed(cfg.inverse_row_y[19:0]);
    assign ycy = $signed(cfg.inverse_row_y[39:20]);
    assign yt  = $signed(cfg.inverse_row_y[59:40]);

    always_comb
    begin
        prod_next[0] = xcx * $signed({1'b0, in_item.pixel_x});
        prod_next[1] = xcy * $signed({1'b0, in_item.pixel_y});
        prod_next[2] = ycx * $signed({1'b0, in_item.pixel_x});
        prod_next[3] = ycy * $signed({1'b0, in_item.pixel_y});
        basex_next = BASE_W'(prod_reg[0]) + BASE_W'(prod_reg[1]) + BASE_W'(xt);
        basey_next = BASE_W'(prod_reg[2]) + BASE_W'(prod_reg[3]) + BASE_W'(yt);
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        localparam int IDX_I = l % SAMPLES_PER_AXIS;
        localparam int IDX_J = l / SAMPLES_PER_AXIS;
        localparam logic signed [9:0] OFF_X =
            10'(((2 * IDX_I + 1) * 256) / (2 * SAMPLES_PER_AXIS));
        localparam logic signed [9:0] OFF_Y =
            10'(((2 * IDX_J + 1) * 256) / (2 * SAMPLES_PER_AXIS));
        logic signed [FULL_W-1:0] fullx, fully;

        always_comb
        begin
            fullx = (FULL_W'(basex_reg) <<< 8) + xcx * OFF_X + xcy * OFF_Y;
            fully = (FULL_W'(basey_reg) <<< 8) + ycx * OFF_X + ycy * OFF_Y;
            ox_next[l] = fullx[FULL_W-1:12];
            oy_next[l] = fully[FULL_W-1:12];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            bg1_reg   <= '{red: in_item.bg_red, green: in_item.bg_green,
                           blue: in_item.bg_blue};
            basex_reg <= basex_next;
            basey_reg <= basey_next;
            bg2_reg   <= bg1_reg;
            ox_reg    <= ox_next;
            oy_reg    <= oy_next;
            bg3_reg   <= bg2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_bg    = bg3_reg;
    assign ox        = ox_reg;
    assign oy        = oy_reg;

endmodule

[sv/ssaa_cov.sv]
// ----------------------------------------------------------------------------
// ssaa_cov
// Three-stage coverage test of every sample against the configured shape.
// ----------------------------------------------------------------------------
module ssaa_cov #(
    parameter int SAMPLES_PER_AXIS = ssaa_pkg::SPA_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  ssaa_pkg::cfg_t                  cfg,
    input  logic                            in_valid,
    input  ssaa_pkg::color_t                in_bg,
    input  logic signed [ssaa_pkg::OBJ_W-1:0] ox [SAMPLES_PER_AXIS*SAMPLES_PER_AXIS],
    input  logic signed [ssaa_pkg::OBJ_W-1:0] oy [SAMPLES_PER_AXIS*SAMPLES_PER_AXIS],
    output logic                            out_valid,
    output ssaa_pkg::color_t                out_bg,
    output logic [SAMPLES_PER_AXIS*SAMPLES_PER_AXIS-1:0] covered
);
    import ssaa_pkg::*;

    localparam int LANES = SAMPLES_PER_AXIS * SAMPLES_PER_AXIS;

    logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy;
    logic signed [EDGE_W-1:0]  ex0, ey0, ex1, ey1, ex2, ey2;
    logic signed [SQ_W-1:0]    rsq;
    logic [LANES-1:0]          cov_next, cov_reg;
    color_t                    bg4_reg, bg5_reg, bg6_reg;
    logic                      v4_reg, v5_reg, v6_reg;

    assign ax  = $signed(cfg.point_a[21:0]);
    assign ay  = $signed(cfg.point_a[43:22]);
    assign bx  = $signed(cfg.point_b[21:0]);
    assign by  = $signed(cfg.point_b[43:22]);
    assign cx  = $signed(cfg.point_c[21:0]);
    assign cy  = $signed(cfg.point_c[43:22]);
    assign ex0 = EDGE_W'(bx) - EDGE_W'(ax);
    assign ey0 = EDGE_W'(by) - EDGE_W'(ay);
    assign ex1 = EDGE_W'(cx) - EDGE_W'(bx);
    assign ey1 = EDGE_W'(cy) - EDGE_W'(by);
    assign ex2 = EDGE_W'(ax) - EDGE_W'(cx);
    assign ey2 = EDGE_W'(ay) - EDGE_W'(cy);
    assign rsq = SQ_W'(bx) * SQ_W'(bx);

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic signed [DIF_W-1:0] dax_reg, day_reg, dbx_reg, dby_reg, dcx_reg, dcy_reg;
        logic                    rect4_reg, rect5_reg;
        logic signed [SQ_W-1:0]  sqx_reg, sqy_reg;
        logic signed [SQ_W-1:0]  e0a_reg, e0b_reg, e1a_reg, e1b_reg, e2a_reg, e2b_reg;
        logic                    rect_next;
        logic signed [SQ_W-1:0]  e0, e1, e2;
        logic                    pos, neg;

        assign rect_next = (ox[l] > OBJ_W'(ax)) && (ox[l] < OBJ_W'(bx)) &&
                           (oy[l] > OBJ_W'(ay)) && (oy[l] < OBJ_W'(by));

        always_comb
        begin
            e0  = e0a_reg - e0b_reg;
            e1  = e1a_reg - e1b_reg;
            e2  = e2a_reg - e2b_reg;
            pos = (e0 > 0) && (e1 > 0) && (e2 > 0);
            neg = (e0 < 0) && (e1 < 0) && (e2 < 0);
            case (cfg.shape_kind)
                KIND_CIRCLE: cov_next[l] = (bx > 0) && ((sqx_reg + sqy_reg) < rsq);
                KIND_RECT:   cov_next[l] = rect5_reg;
                KIND_TRI:    cov_next[l] = pos || neg;
                default:     cov_next[l] = 1'b0;
            endcase
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dax_reg   <= DIF_W'(ox[l]) - DIF_W'(ax);
                day_reg   <= DIF_W'(oy[l]) - DIF_W'(ay);
                dbx_reg   <= DIF_W'(ox[l]) - DIF_W'(bx);
                dby_reg   <= DIF_W'(oy[l]) - DIF_W'(by);
                dcx_reg   <= DIF_W'(ox[l]) - DIF_W'(cx);
                dcy_reg   <= DIF_W'(oy[l]) - DIF_W'(cy);
                rect4_reg <= rect_next;
                sqx_reg   <= SQ_W'(dax_reg) * SQ_W'(dax_reg);
                sqy_reg   <= SQ_W'(day_reg) * SQ_W'(day_reg);
                e0a_reg   <= SQ_W'(dax_reg) * SQ_W'(ey0);
                e0b_reg   <= SQ_W'(day_reg) * SQ_W'(ex0);
                e1a_reg   <= SQ_W'(dbx_reg) * SQ_W'(ey1);
                e1b_reg   <= SQ_W'(dby_reg) * SQ_W'(ex1);
                e2a_reg   <= SQ_W'(dcx_reg) * SQ_W'(ey2);
                e2b_reg   <= SQ_W'(dcy_reg) * SQ_W'(ex2);
                rect5_reg <= rect4_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bg4_reg <= in_bg;
            bg5_reg <= bg4_reg;
            cov_reg <= cov_next;
            bg6_reg <= bg5_reg;
        end
    end

    assign out_valid = v6_reg;
    assign out_bg    = bg6_reg;
    assign covered   = cov_reg;

endmodule

[sv/ssaa_resolve.sv]
// ----------------------------------------------------------------------------
// ssaa_resolve
// Five-stage count, blend and rounded average of the covered samples.
// ----------------------------------------------------------------------------
module ssaa_resolve #(
    parameter int SAMPLES_PER_AXIS = ssaa_pkg::SPA_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  ssaa_pkg::cfg_t                  cfg,
    input  logic                            in_valid,
    input  ssaa_pkg::color_t                in_bg,
    input  logic [SAMPLES_PER_AXIS*SAMPLES_PER_AXIS-1:0] covered,
    output logic                            out_valid,
    output ssaa_pkg::res_item_t             out_item
);
    import ssaa_pkg::*;

    localparam int LANES = SAMPLES_PER_AXIS * SAMPLES_PER_AXIS;
    localparam int CNT_W = $clog2(LANES + 1);
    localparam longint unsigned DEN   = longint'(COLOR_ONE) * longint'(LANES);
    localparam longint unsigned HALF  = DEN / 2;
    localparam longint unsigned RECIP = (64'd1 << 32) / DEN;
    localparam int REM_W = NUM_W + 2;

    logic [COLOR_W-1:0]        alpha;
    logic [COLOR_W-1:0]        fill [3];
    logic [COLOR_W-1:0]        bgc  [3];
    logic [CNT_W-1:0]          cnt7_reg, cnt8_reg, cnt9_reg, cnt10_reg;
    logic [COLOR_W-1:0]        q11_next [3];
    logic [COLOR_W-1:0]        q11_reg  [3];
    logic [COUNT_W-1:0]        sat_next, sat_reg;
    logic [7:0]                cnt_wide;
    logic                      v7_reg, v8_reg, v9_reg, v10_reg, v11_reg;

    assign alpha   = cfg.fill_color_alpha[47:36];
    assign fill[0] = cfg.fill_color_alpha[11:0];
    assign fill[1] = cfg.fill_color_alpha[23:12];
    assign fill[2] = cfg.fill_color_alpha[35:24];
    assign bgc[0]  = in_bg.red;
    assign bgc[1]  = in_bg.green;
    assign bgc[2]  = in_bg.blue;

    for (genvar k = 0; k < 3; k++)
    begin : g_chan
        logic [BLEND_W-1:0] blend_reg;
        logic [BGW_W-1:0]   bgw_reg;
        logic [NUM_W-1:0]   num8_reg, num9_reg, num10_reg;
        logic [63:0]        prod9_reg;
        logic [QUO_W-1:0]   q10_reg, q_fix;
        logic [REM_W-1:0]   qd10_reg, rem;

        always_comb
        begin
            rem         = REM_W'(num10_reg) - qd10_reg;
            q_fix       = (rem >= REM_W'(DEN)) ? q10_reg + QUO_W'(1) : q10_reg;
            q11_next[k] = q_fix[COLOR_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                blend_reg <= BLEND_W'(alpha) * BLEND_W'(fill[k]) +
                             BLEND_W'(COLOR_W'(COLOR_ONE) - alpha) * BLEND_W'(bgc[k]);
                bgw_reg   <= BGW_W'(bgc[k]) * BGW_W'(COLOR_ONE);
                num8_reg  <= NUM_W'(cnt7_reg) * NUM_W'(blend_reg) +
                             NUM_W'(CNT_W'(LANES) - cnt7_reg) * NUM_W'(bgw_reg) +
                             NUM_W'(HALF);
                prod9_reg <= 64'(num8_reg) * 64'(RECIP);
                num9_reg  <= num8_reg;
                q10_reg   <= prod9_reg[32 +: QUO_W];
                qd10_reg  <= REM_W'(prod9_reg[32 +: QUO_W]) * REM_W'(DEN);
                num10_reg <= num9_reg;
            end
        end
    end

    assign cnt_wide = 8'(cnt10_reg);
    assign sat_next = (cnt_wide > 8'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : cnt_wide[COUNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
        end
        else if (en)
        begin
            v7_reg  <= in_valid;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cnt7_reg  <= CNT_W'($countones(covered));
            cnt8_reg  <= cnt7_reg;
            cnt9_reg  <= cnt8_reg;
            cnt10_reg <= cnt9_reg;
            q11_reg   <= q11_next;
            sat_reg   <= sat_next;
        end
    end

    assign out_valid                = v11_reg;
    assign out_item.out_red         = q11_reg[0];
    assign out_item.out_green       = q11_reg[1];
    assign out_item.out_blue        = q11_reg[2];
    assign out_item.covered_samples = sat_reg;

endmodule

[sv/ssaa_shape_pixel_shader_top.sv]
// ----------------------------------------------------------------------------
// ssaa_shape_pixel_shader_top
// Supersampled pixel shader for one configured circle, rectangle or triangle.
//
//   Channel   Direction   Handshake             Payload
//   pix       in          pix_valid/pix_stall   pix_item (coordinate, background)
//   res       out         res_valid/res_stall   res_item (color, covered count)
//   cfg       in          cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One pixel is accepted every cycle while pix_stall is low.
// Its result passes through eleven pipeline stages and then the output register.
// All samples of a pixel are evaluated in parallel lanes.
// A one-entry skid buffer behind the output register absorbs a stall.
// Reset clears all valid bits and the configuration registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssaa_shape_pixel_shader_top #(
    parameter int SAMPLES_PER_AXIS = ssaa_pkg::SPA_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pix_valid,
    output logic                            pix_stall,
    input  ssaa_pkg::pix_item_t             pix_item,
    output logic                            res_valid,
    input  logic                            res_stall,
    output ssaa_pkg::res_item_t             res_item,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ssaa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssaa_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ssaa_pkg::*;

    localparam int LANES = SAMPLES_PER_AXIS * SAMPLES_PER_AXIS;

    cfg_t                    cfg;
    logic                    en;
    logic                    map_valid, cov_valid, core_valid;
    color_t                  map_bg, cov_bg;
    logic signed [OBJ_W-1:0] ox [LANES];
    logic signed [OBJ_W-1:0] oy [LANES];
    logic [LANES-1:0]        covered;
    res_item_t               core_item;
    res_item_t               out_reg, out_next, skid_reg, skid_next;
    logic                    out_v_reg, out_v_next, skid_v_reg, skid_v_next;

    assign en        = !skid_v_reg;
    assign pix_stall = skid_v_reg;

    ssaa_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ssaa_map #(.SAMPLES_PER_AXIS(SAMPLES_PER_AXIS)) u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg),
        .in_valid  (pix_valid),
        .in_item   (pix_item),
        .out_valid (map_valid),
        .out_bg    (map_bg),
        .ox        (ox),
        .oy        (oy)
    );

    ssaa_cov #(.SAMPLES_PER_AXIS(SAMPLES_PER_AXIS)) u_cov (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg),
        .in_valid  (map_valid),
        .in_bg     (map_bg),
        .ox        (ox),
        .oy        (oy),
        .out_valid (cov_valid),
        .out_bg    (cov_bg),
        .covered   (covered)
    );

    ssaa_resolve #(.SAMPLES_PER_AXIS(SAMPLES_PER_AXIS)) u_resolve (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg),
        .in_valid  (cov_valid),
        .in_bg     (cov_bg),
        .covered   (covered),
        .out_valid (core_valid),
        .out_item  (core_item)
    );

    always_comb
    begin
        out_next    = out_reg;
        out_v_next  = out_v_reg;
        skid_next   = skid_reg;
        skid_v_next = skid_v_reg;
        if (!out_v_reg || !res_stall)
        begin
            if (skid_v_reg)
            begin
                out_next    = skid_reg;
                out_v_next  = 1'b1;
                skid_v_next = 1'b0;
            end
            else
            begin
                out_next   = core_item;
                out_v_next = core_valid;
            end
        end
        else if (en && core_valid)
        begin
            skid_next   = core_item;
            skid_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign res_valid = out_v_reg;
    assign res_item  = out_reg;

    `ASSERT_IMPLY(a_count_bound, clk, rst_n, res_valid,
        (res_item.covered_samples <= COUNT_W'(LANES)) ||
        (res_item.covered_samples == COUNT_W'(COUNT_MAX)),
        "covered sample count exceeds the sample grid")
    `ASSERT_IMPLY(a_skid_behind_out, clk, rst_n, skid_v_reg, out_v_reg,
        "skid entry held while the output register is empty")
    `ASSERT_NEXT(a_skid_fill, clk, rst_n, out_v_reg && res_stall && core_valid && en,
        skid_v_reg && out_v_reg,
        "item arriving at a stalled output was not parked in the skid entry")

endmodule

[bench/ssaa_shape_pixel_shader_top_tb.sv]
// ----------------------------------------------------------------------------
// ssaa_shape_pixel_shader_top_tb
// Drives pixels with fixed and random background colors into the shader and checks each
// shaded result against a predictor of the 4x4 supersampled coverage and blend.
// Circles, rectangles, triangles and the unused shape kind are all exercised.
// ----------------------------------------------------------------------------
module ssaa_shape_pixel_shader_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ssaa_pkg::*;

    localparam int GRID = 4;
    localparam int LATENCY = 12;

    logic clk;
    logic rst_n;
    logic pix_valid;
    logic pix_stall;
    pix_item_t pix_item;
    logic res_valid;
    logic res_stall;
    res_item_t res_item;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cfg_t shade_cfg;
    res_item_t shaded_q[$];
    int errors = 0;
    bit sink_idle_ok = 1'b1;
    int hold_cycles = 0;
    int stall_left = 0;

    ssaa_shape_pixel_shader_top dut (
        .clk(clk), .rst_n(rst_n),
        .pix_valid(pix_valid), .pix_stall(pix_stall), .pix_item(pix_item),
        .res_valid(res_valid), .res_stall(res_stall), .res_item(res_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint sx_ext(logic [63:0] v, int w);
        logic [63:0] m;
        m = (64'd1 << w) - 1;
        v = v & m;
        if (v[w-1])
            return longint'(v) - longint'(64'd1 << w);
        return longint'(v);
    endfunction

    function automatic longint map_row(logic [59:0] row, longint sx, longint sy);
        longint s;
        s = sx_ext(row[19:0], 20) * sx + sx_ext(row[39:20], 20) * sy
            + sx_ext(row[59:40], 20) * 256;
        return s >>> 12;
    endfunction

    function automatic longint px_of(logic [43:0] p);
        return sx_ext(p[21:0], 22);
    endfunction

    function automatic longint py_of(logic [43:0] p);
        return sx_ext(p[43:22], 22);
    endfunction

    function automatic longint edge_val(longint ox, longint oy, logic [43:0] p,
                                        logic [43:0] q);
        return (ox - px_of(p)) * (py_of(q) - py_of(p))
             - (oy - py_of(p)) * (px_of(q) - px_of(p));
    endfunction

    function automatic bit sample_hit(longint ox, longint oy);
        longint r, dx, dy, e0, e1, e2;
        case (shade_cfg.shape_kind)
            KIND_CIRCLE:
            begin
                r = px_of(shade_cfg.point_b);
                if (r <= 0)
                    return 1'b0;
                dx = ox - px_of(shade_cfg.point_a);
                dy = oy - py_of(shade_cfg.point_a);
                return dx * dx + dy * dy < r * r;
            end
            KIND_RECT:
                return ox > px_of(shade_cfg.point_a) && ox < px_of(shade_cfg.point_b)
                    && oy > py_of(shade_cfg.point_a) && oy < py_of(shade_cfg.point_b);
            KIND_TRI:
            begin
                e0 = edge_val(ox, oy, shade_cfg.point_a, shade_cfg.point_b);
                e1 = edge_val(ox, oy, shade_cfg.point_b, shade_cfg.point_c);
                e2 = edge_val(ox, oy, shade_cfg.point_c, shade_cfg.point_a);
                return (e0 > 0 && e1 > 0 && e2 > 0) || (e0 < 0 && e1 < 0 && e2 < 0);
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic res_item_t shade_pixel(pix_item_t p);
        res_item_t r;
        longint sx, sy, cnt, alpha, blend, num, den, fill, bg;
        cnt = 0;
        for (int j = 0; j < GRID; j++)
        begin
            sy = longint'(p.pixel_y) * 256 + ((2 * j + 1) * 256) / (2 * GRID);
            for (int i = 0; i < GRID; i++)
            begin
                sx = longint'(p.pixel_x) * 256 + ((2 * i + 1) * 256) / (2 * GRID);
                if (sample_hit(map_row(shade_cfg.inverse_row_x, sx, sy),
                               map_row(shade_cfg.inverse_row_y, sx, sy)))
                    cnt++;
            end
        end
        alpha = shade_cfg.fill_color_alpha[47:36];
        den = COLOR_ONE * GRID * GRID;
        for (int k = 0; k < 3; k++)
        begin
            fill = (shade_cfg.fill_color_alpha >> (12 * k)) & 12'hFFF;
            bg = (k == 0) ? p.bg_red : (k == 1) ? p.bg_green : p.bg_blue;
            blend = alpha * fill + (COLOR_ONE - alpha) * bg;
            num = cnt * blend + (GRID * GRID - cnt) * COLOR_ONE * bg;
            case (k)
                0: r.out_red = 12'((num + den / 2) / den);
                1: r.out_green = 12'((num + den / 2) / den);
                default: r.out_blue = 12'((num + den / 2) / den);
            endcase
        end
        r.covered_samples = (cnt > COUNT_MAX) ? 5'(COUNT_MAX) : 5'(cnt);
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SHAPE_KIND: shade_cfg.shape_kind = val[1:0];
            CFG_INV_ROW_X:  shade_cfg.inverse_row_x = val[59:0];
            CFG_INV_ROW_Y:  shade_cfg.inverse_row_y = val[59:0];
            CFG_POINT_A:    shade_cfg.point_a = val[43:0];
            CFG_POINT_B:    shade_cfg.point_b = val[43:0];
            CFG_POINT_C:    shade_cfg.point_c = val[43:0];
            CFG_FILL_COLOR: shade_cfg.fill_color_alpha = val[47:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_pixel(pix_item_t p, bit gaps);
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_item <= p;
        do
            @(posedge clk);
        while (pix_stall);
        shaded_q.push_back(shade_pixel(p));
    endtask

    task automatic drain();
        pix_valid <= 1'b0;
        while (shaded_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [43:0] pt(int x, int y);
        logic [21:0] a, b;
        a = 22'(x);
        b = 22'(y);
        return {b, a};
    endfunction

    function automatic logic [59:0] row(int cx, int cy, int t);
        logic [19:0] a, b, c;
        a = 20'(cx);
        b = 20'(cy);
        c = 20'(t);
        return {c, b, a};
    endfunction

    function automatic pix_item_t rand_pixel(int lo, int hi);
        pix_item_t p;
        p.pixel_x = 12'($urandom_range(lo, hi));
        p.pixel_y = 12'($urandom_range(lo, hi));
        p.bg_red = 12'($urandom);
        p.bg_green = 12'($urandom);
        p.bg_blue = 12'($urandom);
        return p;
    endfunction

    task automatic identity_view();
        write_reg(CFG_INV_ROW_X, row(4096, 0, 0));
        write_reg(CFG_INV_ROW_Y, row(0, 4096, 0));
    endtask

    task automatic test_directed();
        pix_item_t p;
        identity_view();
        write_reg(CFG_SHAPE_KIND, KIND_CIRCLE);
        write_reg(CFG_POINT_A, pt(8 * 256, 8 * 256));
        write_reg(CFG_POINT_B, pt(3 * 256, 0));
        write_reg(CFG_FILL_COLOR, {12'hFFF, 12'hFFF, 12'h000, 12'hFFF});
        for (int y = 4; y < 13; y += 2)
            send_pixel('{pixel_x: 8, pixel_y: y, bg_red: 0, bg_green: 12'hFFF,
                         bg_blue: 12'h800}, 1'b0);
        send_pixel('{pixel_x: 12'hFFF, pixel_y: 12'hFFF, bg_red: 12'hFFF,
                     bg_green: 12'hFFF, bg_blue: 12'hFFF}, 1'b0);
        send_pixel('{pixel_x: 0, pixel_y: 0, bg_red: 0, bg_green: 0, bg_blue: 0}, 1'b0);
        drain();
        write_reg(CFG_POINT_B, pt(-256, 0));
        send_pixel('{pixel_x: 8, pixel_y: 8, bg_red: 5, bg_green: 6, bg_blue: 7}, 1'b0);
        drain();
        write_reg(CFG_SHAPE_KIND, KIND_RECT);
        write_reg(CFG_POINT_A, pt(2 * 256 + 64, 2 * 256));
        write_reg(CFG_POINT_B, pt(6 * 256, 5 * 256 + 128));
        for (int x = 1; x < 8; x++)
            send_pixel('{pixel_x: x, pixel_y: x, bg_red: 100, bg_green: 200,
                         bg_blue: 300}, 1'b0);
        drain();
        write_reg(CFG_SHAPE_KIND, KIND_TRI);
        write_reg(CFG_POINT_A, pt(0, 0));
        write_reg(CFG_POINT_B, pt(10 * 256, 0));
        write_reg(CFG_POINT_C, pt(0, 10 * 256));
        for (int x = 0; x < 6; x++)
            send_pixel('{pixel_x: x * 2, pixel_y: 3, bg_red: 1, bg_green: 2,
                         bg_blue: 3}, 1'b0);
        drain();
        write_reg(CFG_POINT_B, pt(0, 0));
        write_reg(CFG_POINT_C, pt(0, 0));
        send_pixel('{pixel_x: 0, pixel_y: 0, bg_red: 9, bg_green: 9, bg_blue: 9}, 1'b0);
        drain();
        write_reg(CFG_SHAPE_KIND, KIND_UNUSED);
        write_reg(CFG_UNUSED, '1);
        p = rand_pixel(0, 4095);
        send_pixel(p, 1'b0);
        drain();
    endtask

    task automatic random_scene();
        int kind;
        kind = $urandom_range(0, 3);
        write_reg(CFG_SHAPE_KIND, 60'(kind));
        if ($urandom_range(0, 3) == 0)
        begin
            write_reg(CFG_INV_ROW_X, 60'({$urandom, $urandom}));
            write_reg(CFG_INV_ROW_Y, 60'({$urandom, $urandom}));
        end
        else
        begin
            write_reg(CFG_INV_ROW_X, row($urandom_range(2048, 8192),
                      int'($urandom_range(0, 2048)) - 1024,
                      int'($urandom_range(0, 4096)) - 2048));
            write_reg(CFG_INV_ROW_Y, row(int'($urandom_range(0, 2048)) - 1024,
                      $urandom_range(2048, 8192), int'($urandom_range(0, 4096)) - 2048));
        end
        write_reg(CFG_POINT_A, pt($urandom_range(0, 8192), $urandom_range(0, 8192)));
        if (kind == int'(KIND_CIRCLE))
            write_reg(CFG_POINT_B, 60'({$urandom, 22'h0}) |
                      60'(pt(int'($urandom_range(0, 6000)) - 256, 0)));
        else
            write_reg(CFG_POINT_B, pt($urandom_range(0, 8192), $urandom_range(0, 8192)));
        write_reg(CFG_POINT_C, pt($urandom_range(0, 8192), $urandom_range(0, 8192)));
        write_reg(CFG_FILL_COLOR, 60'({$urandom, $urandom}));
    endtask

    task automatic test_random(int scenes, int per_scene, bit gaps);
        pix_item_t p;
        for (int s = 0; s < scenes; s++)
        begin
            random_scene();
            for (int n = 0; n < per_scene; n++)
            begin
                p = ($urandom_range(0, 9) == 0) ? rand_pixel(0, 4095) : rand_pixel(0, 34);
                send_pixel(p, gaps);
            end
            drain();
        end
    endtask

    task automatic test_backpressure();
        random_scene();
        hold_cycles = 60;
        for (int n = 0; n < 40; n++)
            send_pixel(rand_pixel(0, 34), 1'b0);
        drain();
    endtask

    task automatic test_extreme_config();
        write_reg(CFG_SHAPE_KIND, KIND_UNUSED);
        write_reg(CFG_INV_ROW_X, '1);
        write_reg(CFG_INV_ROW_Y, '0);
        write_reg(CFG_POINT_A, '1);
        write_reg(CFG_POINT_B, '0);
        write_reg(CFG_POINT_C, '1);
        write_reg(CFG_FILL_COLOR, '1);
        for (int n = 0; n < 4; n++)
            send_pixel(rand_pixel(0, 4095), 1'b1);
        drain();
        write_reg(CFG_SHAPE_KIND, KIND_TRI);
        for (int n = 0; n < 8; n++)
            send_pixel(rand_pixel(0, 4095), 1'b1);
        drain();
        write_reg(CFG_INV_ROW_X, {20'h80000, 20'h80000, 20'h80000});
        write_reg(CFG_INV_ROW_Y, {20'h7FFFF, 20'h7FFFF, 20'h7FFFF});
        write_reg(CFG_SHAPE_KIND, KIND_CIRCLE);
        write_reg(CFG_POINT_B, pt(22'h1FFFFF, 0));
        write_reg(CFG_FILL_COLOR, '0);
        for (int n = 0; n < 8; n++)
            send_pixel(rand_pixel(0, 4095), 1'b1);
        drain();
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            res_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else if (stall_left > 0)
        begin
            res_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (sink_idle_ok && $urandom_range(0, 5) == 0)
        begin
            res_stall <= 1'b1;
            stall_left <= $urandom_range(0, 6);
        end
        else
            res_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        res_item_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (shaded_q.size() == 0)
            begin
                $error("unexpected result %h", res_item);
                errors++;
            end
            else
            begin
                want = shaded_q.pop_front();
                if (res_item.out_red !== want.out_red)
                begin
                    $error("out_red expected %0d actual %0d", want.out_red,
                           res_item.out_red);
                    errors++;
                end
                if (res_item.out_green !== want.out_green)
                begin
                    $error("out_green expected %0d actual %0d", want.out_green,
                           res_item.out_green);
                    errors++;
                end
                if (res_item.out_blue !== want.out_blue)
                begin
                    $error("out_blue expected %0d actual %0d", want.out_blue,
                           res_item.out_blue);
                    errors++;
                end
                if (res_item.covered_samples !== want.covered_samples)
                begin
                    $error("covered_samples expected %0d actual %0d",
                           want.covered_samples, res_item.covered_samples);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("ssaa_shape_pixel_shader_top_tb: errors");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        pix_valid = 1'b0;
        pix_item = '0;
        res_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        shade_cfg = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_extreme_config();
        test_backpressure();
        test_random(20, 35, 1'b1);
        sink_idle_ok = 1'b0;
        test_random(4, 30, 1'b0);
        repeat (LATENCY + 8) @(posedge clk);
        if (errors == 0 && shaded_q.size() == 0)
            $display("ssaa_shape_pixel_shader_top_tb: clean");
        else
            $display("ssaa_shape_pixel_shader_top_tb: errors");
        $finish;
    end
endmodule

[files.f]
+incdir+sv
sv/ssaa_pkg.sv
sv/ssaa_cfg.sv
sv/ssaa_map.sv
sv/ssaa_cov.sv
sv/ssaa_resolve.sv
sv/ssaa_shape_pixel_shader_top.sv
bench/ssaa_shape_pixel_shader_top_tb.sv
